/* rtl/core/sha_pkg.sv */
// ----------------------------------------------------------------------------
// sha_pkg
// Types, constants and round functions shared by the SHA-256 hasher modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

  localparam int SHA_LENGTH_BITS = 64;

  localparam logic [31:0] SHA_PAD_MARK = 32'h8000_0000;
  localparam logic [7:0]  SHA_PAD_BYTE = 8'h80;
  localparam logic [5:0]  SHA_LAST_ROUND = 6'd63;
  localparam logic [3:0]  SHA_LAST_POS = 4'd15;
  localparam logic [3:0]  SHA_LEN_POS = 4'd14;
  localparam logic [3:0]  SHA_DIGEST_WORDS = 4'd8;
  localparam logic [2:0]  SHA_FULL_BYTES = 3'd4;

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_ADD,
    S_DONE
  } sha_state_t;

  typedef enum logic [1:0] {
    PH_MARK,
    PH_ZERO,
    PH_LEN_LO,
    PH_DONE
  } sha_phase_t;

  typedef struct packed {
    logic        push;
    logic        start;
    logic        rnd;
    logic        add;
    logic        init;
    logic [5:0]  idx;
  } sha_ctrl_t;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  valid_bytes;
    logic        is_final;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_done;
  } sha_out_t;

  function automatic logic [31:0] sha_ror(input logic [31:0] x, input int n);
    sha_ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sha_bsig0(input logic [31:0] x);
    sha_bsig0 = sha_ror(x, 2) ^ sha_ror(x, 13) ^ sha_ror(x, 22);
  endfunction

  function automatic logic [31:0] sha_bsig1(input logic [31:0] x);
    sha_bsig1 = sha_ror(x, 6) ^ sha_ror(x, 11) ^ sha_ror(x, 25);
  endfunction

  function automatic logic [31:0] sha_ssig0(input logic [31:0] x);
    sha_ssig0 = sha_ror(x, 7) ^ sha_ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sha_ssig1(input logic [31:0] x);
    sha_ssig1 = sha_ror(x, 17) ^ sha_ror(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/sha_sched.sv */
// ----------------------------------------------------------------------------
// sha_sched
// Block buffer and message schedule: a 16-word shift line that is filled one
// word per push and expands itself one word per round.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_sched (
  input  wire logic              clk,
  input  wire sha_pkg::sha_ctrl_t ctrl,
  input  wire logic [31:0]       push_word,
  output logic [31:0]            w_cur
);
  import sha_pkg::*;

  logic [31:0] w_r   [16];
  logic [31:0] w_nxt [16];
  logic [31:0] w_new;

  // w_r[k] holds schedule word t+k during round t
  assign w_new = w_r[0] + sha_ssig0(w_r[1]) + w_r[9] + sha_ssig1(w_r[14]);
  assign w_cur = w_r[0];

  always_comb begin
    for (int k = 0; k < 15; k++) begin
      w_nxt[k] = w_r[k + 1];
    end
    w_nxt[15] = ctrl.push ? push_word : w_new;
  end

  always_ff @(posedge clk) begin
    if (ctrl.push || ctrl.rnd) begin
      for (int k = 0; k < 16; k++) begin
        w_r[k] <= w_nxt[k];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sha_round.sv */
// ----------------------------------------------------------------------------
// sha_round
// Working variables, one compression round per cycle, and the chaining state.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_round (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sha_pkg::sha_ctrl_t ctrl,
  input  wire logic [31:0]        w_cur,
  output logic [7:0][31:0]        chain
);
  import sha_pkg::*;

  logic [31:0] chain_r [8];
  logic [31:0] wv_r    [8];
  logic [31:0] wv_nxt  [8];
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  always_comb begin
    ch  = (wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]);
    maj = (wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]);
    t1  = wv_r[7] + sha_bsig1(wv_r[4]) + ch + SHA_K[ctrl.idx] + w_cur;
    t2  = sha_bsig0(wv_r[0]) + maj;
    wv_nxt[0] = t1 + t2;
    wv_nxt[1] = wv_r[0];
    wv_nxt[2] = wv_r[1];
    wv_nxt[3] = wv_r[2];
    wv_nxt[4] = wv_r[3] + t1;
    wv_nxt[5] = wv_r[4];
    wv_nxt[6] = wv_r[5];
    wv_nxt[7] = wv_r[6];
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      wv_r <= chain_r;
    end else if (ctrl.rnd) begin
      wv_r <= wv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.init) begin
      chain_r <= SHA_IV;
    end else if (ctrl.add) begin
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= chain_r[i] + wv_r[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      chain[i] = chain_r[i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sha256_message_hasher.sv */
// ----------------------------------------------------------------------------
// sha256_message_hasher
// SHA-256 digest of one message at a time, one compression round per cycle.
// ----------------------------------------------------------------------------
// Message words are taken one beat per cycle, while the hasher is idle, into a
// 16-word buffer. The word that completes a block holds the input for the 64
// rounds of the shared round unit and the fold of the result into the chaining
// state. The final word starts the padding sequencer, which pushes one padding
// or length word per cycle, pausing while each block it completes is compressed.
// The eight digest words then leave through an output register, index 0 first,
// one per beat; the next message may start while they drain, and its digest
// waits until the previous one has left completely.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_message_hasher #(
  parameter int LENGTH_BITS = sha_pkg::SHA_LENGTH_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire sha_pkg::sha_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output sha_pkg::sha_out_t     out_data
);
  import sha_pkg::*;

  sha_state_t             state_r, state_nxt;
  sha_phase_t             phase_r, phase_nxt;
  logic                   fin_r;
  logic [3:0]             pos_r;
  logic [5:0]             rnd_r;
  logic [LENGTH_BITS-1:0] bit_cnt_r;
  logic [31:0]            dig_r [8];
  logic [2:0]             idx_r;
  logic [3:0]             out_left_r;

  sha_ctrl_t              ctrl;
  logic [31:0]            push_data;
  logic [31:0]            first_word;
  logic [31:0]            w_cur;
  logic [7:0][31:0]       chain;
  logic [63:0]            len64;
  logic [2:0]             nb_eff;
  logic                   in_acc;
  logic                   out_acc;
  logic                   dig_load;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = (out_left_r != 4'd0);
  assign out_acc  = out_valid && !out_stall;
  assign dig_load = (state_r == S_DONE) && (out_left_r == 4'd0);
  assign len64    = 64'(bit_cnt_r);

  always_comb begin
    if (!in_data.is_final || in_data.valid_bytes > SHA_FULL_BYTES) begin
      nb_eff = SHA_FULL_BYTES;
    end else begin
      nb_eff = in_data.valid_bytes;
    end
  end

  // low bytes past the valid count become 0x80 then zeros
  always_comb begin
    case (nb_eff)
      3'd0:    first_word = SHA_PAD_MARK;
      3'd1:    first_word = {in_data.message_word[31:24], SHA_PAD_BYTE, 16'h0000};
      3'd2:    first_word = {in_data.message_word[31:16], SHA_PAD_BYTE, 8'h00};
      3'd3:    first_word = {in_data.message_word[31:8], SHA_PAD_BYTE};
      default: first_word = in_data.message_word;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (pos_r == SHA_LAST_POS) begin
            state_nxt = S_ROUND;
          end else if (in_data.is_final) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (pos_r == SHA_LAST_POS) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        if (rnd_r == SHA_LAST_ROUND) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        if (!fin_r) begin
          state_nxt = S_IDLE;
        end else if (phase_r == PH_DONE) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_PAD;
        end
      end
      S_DONE: begin
        if (out_left_r == 4'd0) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl      = '0;
    ctrl.idx  = rnd_r;
    push_data = first_word;
    phase_nxt = phase_r;
    case (state_r)
      S_IDLE: begin
        ctrl.push = in_acc;
        if (in_acc && in_data.is_final) begin
          phase_nxt = (nb_eff == SHA_FULL_BYTES) ? PH_MARK : PH_ZERO;
        end
      end
      S_PAD: begin
        ctrl.push = 1'b1;
        case (phase_r)
          PH_MARK: begin
            push_data = SHA_PAD_MARK;
            phase_nxt = PH_ZERO;
          end
          PH_ZERO: begin
            if (pos_r == SHA_LEN_POS) begin
              push_data = len64[63:32];
              phase_nxt = PH_LEN_LO;
            end else begin
              push_data = 32'h0000_0000;
            end
          end
          PH_LEN_LO: begin
            push_data = len64[31:0];
            phase_nxt = PH_DONE;
          end
          default: begin
            ctrl.push = 1'b0;
          end
        endcase
      end
      S_ROUND: begin
        ctrl.rnd = 1'b1;
      end
      S_ADD: begin
        ctrl.add = 1'b1;
      end
      S_DONE: begin
        ctrl.init = dig_load;
      end
      default: begin
        ctrl = '0;
      end
    endcase
    ctrl.start = ctrl.push && (pos_r == SHA_LAST_POS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      phase_r   <= PH_MARK;
      fin_r     <= 1'b0;
      pos_r     <= '0;
      rnd_r     <= '0;
      bit_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      if (ctrl.push) begin
        pos_r <= pos_r + 4'd1;
      end
      if (ctrl.rnd) begin
        rnd_r <= rnd_r + 6'd1;
      end
      if (in_acc) begin
        bit_cnt_r <= bit_cnt_r + LENGTH_BITS'({nb_eff, 3'b000});
        if (in_data.is_final) begin
          fin_r <= 1'b1;
        end
      end
      if (dig_load) begin
        fin_r     <= 1'b0;
        bit_cnt_r <= '0;
      end
    end
  end

  // digest output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_left_r <= '0;
      idx_r      <= '0;
    end else if (dig_load) begin
      out_left_r <= SHA_DIGEST_WORDS;
      idx_r      <= '0;
    end else if (out_acc) begin
      out_left_r <= out_left_r - 4'd1;
      idx_r      <= idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (dig_load) begin
      for (int i = 0; i < 8; i++) begin
        dig_r[i] <= chain[i];
      end
    end else if (out_acc) begin
      for (int i = 0; i < 7; i++) begin
        dig_r[i] <= dig_r[i + 1];
      end
    end
  end

  assign out_data.digest_word = dig_r[0];
  assign out_data.word_index  = idx_r;
  assign out_data.digest_done = (idx_r == 3'd7);

  sha_sched u_sched (
    .clk       (clk),
    .ctrl      (ctrl),
    .push_word (push_data),
    .w_cur     (w_cur)
  );

  sha_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .w_cur (w_cur),
    .chain (chain)
  );

`ifndef SYNTH
  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && rnd_r == SHA_LAST_ROUND) |=> (state_r == S_ADD))
    else $error("round sequence did not end in chaining add");

  a_block_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND || state_r == S_ADD || state_r == S_DONE) |-> (pos_r == 4'd0))
    else $error("compression running with partial block");

  a_round_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.start) |=> (rnd_r == 6'd0 && state_r == S_ROUND))
    else $error("block compression did not start at round zero");

  a_digest_load: assert property (@(posedge clk) disable iff (!rst_n)
    (dig_load) |=> (out_left_r == SHA_DIGEST_WORDS && idx_r == 3'd0 && !fin_r))
    else $error("digest load did not set up eight output beats");

  a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid) |-> (out_left_r + 4'(idx_r) == SHA_DIGEST_WORDS))
    else $error("output count and index out of step");
`endif

endmodule

`default_nettype wire

/* tb/sv/sha256_message_hasher_tb.sv */
// ----------------------------------------------------------------------------
// sha256_message_hasher_tb
// Self-checking bench for the SHA-256 hasher: random messages, random pacing.
// ----------------------------------------------------------------------------
// A driver pushes message words from a queue and a monitor takes digest
// beats with random stalls. A behavioral SHA-256 runs on every accepted word
// and queues the eight digest beats each final word must produce. The
// directed part covers the empty message, short tails, byte counts above
// four, ignored byte counts on inner words and a tail that forces a second
// padding block. One long output stall backs the block up into its input.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_message_hasher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sha_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 200;
  localparam int TOTAL_ITEMS = 160;
  localparam int PRESSURE_AT = 80;
  localparam int PRESSURE_CYCLES = 400;

  localparam logic [31:0] PAD_WORD = 32'h8000_0000;
  localparam logic [31:0] PAD_BYTE = 32'h0000_0080;
  localparam logic [3:0]  LEN_SLOT = 4'd14;
  localparam int          FULL_WORD = 4;

  localparam logic [0:7][31:0] START_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  sha_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  sha_out_t out_data;

  sha256_message_hasher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  sha_in_t     word_q[$];
  sha_out_t    digest_q[$];
  logic [31:0] hash_state [8];
  logic [31:0] blk [16];
  logic [3:0]  blk_pos;
  logic [63:0] msg_bits;

  logic in_acc = 1'b0;
  logic out_acc = 1'b0;
  int   in_gap = 0;
  int   out_hold = 0;
  int   n_launched = 0;
  int   n_results = 0;
  int   n_errors = 0;
  int   idle_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- hashing

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    logic [63:0] both;
    both = {x, x} >> n;
    return both[31:0];
  endfunction

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = START_HASH[i];
    blk_pos = '0;
    msg_bits = '0;
  endtask

  task automatic compress_blk();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] wr, s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        s0 = rotr(w[(r + 1) % 16], 7) ^ rotr(w[(r + 1) % 16], 18) ^ (w[(r + 1) % 16] >> 3);
        s1 = rotr(w[(r + 14) % 16], 17) ^ rotr(w[(r + 14) % 16], 19)
             ^ (w[(r + 14) % 16] >> 10);
        wr = w[r % 16] + s0 + w[(r + 9) % 16] + s1;
        w[r % 16] = wr;
      end
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_K[r] + wr;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endtask

  task automatic absorb(input logic [31:0] w);
    blk[blk_pos] = w;
    blk_pos = blk_pos + 4'd1;
    if (blk_pos == 4'd0) compress_blk();
  endtask

  task automatic hash_word(input sha_in_t it);
    int          nb;
    logic [31:0] keep;
    sha_out_t    beat;
    nb = it.valid_bytes;
    // byte count only counts on the last word, and saturates at four
    if (!it.is_final || nb > FULL_WORD) nb = FULL_WORD;
    msg_bits = msg_bits + 64'(8 * nb);
    if (!it.is_final) begin
      absorb(it.message_word);
    end else begin
      if (nb < FULL_WORD) begin
        keep = (nb == 0) ? '0 : ~(32'hFFFF_FFFF >> (8 * nb));
        absorb((it.message_word & keep) | (PAD_BYTE << (24 - 8 * nb)));
      end else begin
        absorb(it.message_word);
        absorb(PAD_WORD);
      end
      while (blk_pos != LEN_SLOT) absorb('0);
      absorb(msg_bits[63:32]);
      absorb(msg_bits[31:0]);
      for (int i = 0; i < 8; i++) begin
        beat.digest_word = hash_state[i];
        beat.word_index = 3'(i);
        beat.digest_done = (i == 7);
        digest_q = {digest_q, beat};
      end
      restart_hash();
    end
  endtask

  // --------------------------------------------------------------- stimulus

  // random pacing, with every other run of 32 beats at full speed
  function automatic int pace(input int beat);
    if (beat % 64 >= 32) return 0;
    return $urandom_range(0, 9);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_word(input logic [31:0] w, input int nb, input bit last);
    sha_in_t it;
    it.message_word = w;
    it.valid_bytes = 3'(nb);
    it.is_final = last;
    word_q = {word_q, it};
  endtask

  task automatic queue_message(input int n_words);
    for (int i = 0; i < n_words; i++) begin
      queue_word(rand_word(), ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : FULL_WORD,
                 1'b0);
    end
    queue_word(rand_word(), $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, 7),
               1'b1);
  endtask

  initial begin : stimulus
    int pick;
    int len;
    restart_hash();
    // empty message and a one-byte message, with junk in the unused bits
    queue_word(32'hFFFF_FFFF, 0, 1'b1);
    queue_word(32'hFFFF_FFFF, 1, 1'b1);
    // "abc" with a stray low byte that must be replaced by the pad marker
    queue_word(32'h6162_63FF, 3, 1'b1);
    // byte count above four on the last word
    queue_word(32'h6162_6364, 7, 1'b1);
    // inner word with a zero byte count still carries four bytes
    queue_word(32'h0000_0000, 0, 1'b0);
    queue_word(32'h1234_5678, 2, 1'b1);
    // 60-byte message: length no longer fits, second padding block
    for (int i = 0; i < 14; i++) begin
      queue_word(i[0] ? 32'hFFFF_FFFF : 32'h0000_0000, (i == 5) ? 5 : FULL_WORD, 1'b0);
    end
    queue_word(32'hA5A5_5A5A, 4, 1'b1);

    while (word_q.size() < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) len = $urandom_range(0, 12);
      else if (pick < 17) len = $urandom_range(13, 17);
      else if (pick < 19) len = $urandom_range(18, 40);
      else len = $urandom_range(60, 70);
      // last message is cut so the run stays at the planned word count
      if (word_q.size() + len + 1 > TOTAL_ITEMS) len = TOTAL_ITEMS - word_q.size() - 1;
      queue_message(len);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (word_q.size() != 0 || in_valid || digest_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // ----------------------------------------------------------------- driver

  always @(posedge clk) begin
    in_acc <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      hash_word(in_data);
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_acc) begin
      // stalled beat stays as it is
    end else if (in_gap != 0) begin
      in_valid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (word_q.size() != 0) begin
      in_data <= word_q.pop_front();
      in_valid <= 1'b1;
      in_gap <= pace(n_launched);
      n_launched <= n_launched + 1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : digest_check
    sha_out_t want;
    out_acc <= rst_n && out_valid && !out_stall;
    if (rst_n && out_valid && !out_stall) begin
      n_results <= n_results + 1;
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest beat word %h index %0d done %0b", $time,
                 out_data.digest_word, out_data.word_index, out_data.digest_done);
        n_errors++;
      end else begin
        want = digest_q.pop_front();
        if (out_data.digest_word !== want.digest_word) begin
          $display("%0t: digest_word expected %h actual %h", $time,
                   want.digest_word, out_data.digest_word);
          n_errors++;
        end
        if (out_data.word_index !== want.word_index) begin
          $display("%0t: word_index expected %0d actual %0d", $time,
                   want.word_index, out_data.word_index);
          n_errors++;
        end
        if (out_data.digest_done !== want.digest_done) begin
          $display("%0t: digest_done expected %0b actual %0b", $time,
                   want.digest_done, out_data.digest_done);
          n_errors++;
        end
      end
    end
  end

  always @(negedge clk) begin : out_pace
    int hold;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold <= 0;
    end else if (out_acc) begin
      // one long hold-off so the block backs up into its input
      hold = (n_results == PRESSURE_AT) ? PRESSURE_CYCLES : pace(n_results);
      out_stall <= (hold != 0);
      out_hold <= (hold != 0) ? hold - 1 : 0;
    end else if (out_hold != 0) begin
      out_hold <= out_hold - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/core/sha_pkg.sv
rtl/core/sha_sched.sv
rtl/core/sha_round.sv
rtl/core/sha256_message_hasher.sv
tb/sv/sha256_message_hasher_tb.sv
